// ===== sv/slcd_pkg.sv =====
// Shared types, codes and tables for the segment LCD serial writer.
// Depends on nothing; every other file of the block refers to it by scoped names.
`timescale 1ns / 1ps

package slcd_pkg;

   // Number of zero nibbles sent by a clear frame.
   localparam int CLEAR_NIBBLES = 32;

   // Frame lengths in bits.
   localparam int CMD_BITS    = 12;
   localparam int DIGIT_BITS  = 73;
   localparam int CLEAR_BITS  = 9 + 4 * CLEAR_NIBBLES;
   localparam int MAX_BITS    = (CLEAR_BITS > DIGIT_BITS) ? CLEAR_BITS : DIGIT_BITS;
   localparam int POS_W       = $clog2(MAX_BITS + 1);

   // Field widths.
   localparam int TICK_W      = 10;
   localparam int CSR_IDX_W   = 1;
   localparam int CMD_W       = 3;
   localparam int DIGIT_W     = 4;
   localparam int BYTE_W      = 8;

   // Configuration register indexes.
   localparam logic [CSR_IDX_W-1:0] CSR_WR_LOW  = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_WR_HIGH = 1'b1;

   // Reset values of the strobe timing registers.
   localparam logic [TICK_W-1:0] WR_LOW_RESET  = TICK_W'(20);
   localparam logic [TICK_W-1:0] WR_HIGH_RESET = TICK_W'(1);

   // Request codes.
   localparam logic [CMD_W-1:0] CMD_NONE      = 3'd0;
   localparam logic [CMD_W-1:0] CMD_DIGITS    = 3'd1;
   localparam logic [CMD_W-1:0] CMD_POINT     = 3'd2;
   localparam logic [CMD_W-1:0] CMD_SEND      = 3'd3;
   localparam logic [CMD_W-1:0] CMD_CLEAR     = 3'd4;
   localparam logic [CMD_W-1:0] CMD_BACKLIGHT = 3'd5;

   // Kind of frame in flight; idle when none.
   typedef enum logic [1:0] {
      KIND_IDLE   = 2'd0,
      KIND_CMD    = 2'd1,
      KIND_CLEAR  = 2'd2,
      KIND_DIGITS = 2'd3
   } frame_kind_type;

   typedef logic [POS_W-1:0] bit_pos_type;

   // Segment bytes shown at reset.
   localparam logic [3:0][BYTE_W-1:0] SEGMENTS_RESET = {8'h0e, 8'h7f, 8'h78, 8'h5e};

   // Number of bits of each frame kind; zero when idle.
   function automatic bit_pos_type frame_len(input frame_kind_type kind);
      bit_pos_type len;
      case (kind)
         KIND_CMD:    len = POS_W'(CMD_BITS);
         KIND_CLEAR:  len = POS_W'(CLEAR_BITS);
         KIND_DIGITS: len = POS_W'(DIGIT_BITS);
         default:     len = '0;
      endcase
      return len;
   endfunction

   // Segment byte for a digit code; codes twelve and up are blank.
   function automatic logic [BYTE_W-1:0] seg_code(input logic [DIGIT_W-1:0] code);
      logic [BYTE_W-1:0] seg;
      case (code)
         4'd0:    seg = 8'h5f;
         4'd1:    seg = 8'h06;
         4'd2:    seg = 8'h3d;
         4'd3:    seg = 8'h2f;
         4'd4:    seg = 8'h66;
         4'd5:    seg = 8'h6b;
         4'd6:    seg = 8'h7b;
         4'd7:    seg = 8'h0e;
         4'd8:    seg = 8'h7f;
         4'd9:    seg = 8'h6f;
         4'd10:   seg = 8'h5e;
         4'd11:   seg = 8'h78;
         default: seg = 8'h00;
      endcase
      return seg;
   endfunction

endpackage

// ===== sv/slcd_if.sv =====
// Handshake channel interfaces of the segment LCD serial writer: request, response, CSR.
// Depends on slcd_pkg for field widths.
`timescale 1ns / 1ps

// Request channel: one tick of the pin sequencer per transaction.
interface slcd_req_if;
   logic                           valid;
   logic                           ready;
   logic [slcd_pkg::CMD_W-1:0]     cmd;
   logic [slcd_pkg::DIGIT_W-1:0]   digit_a;
   logic [slcd_pkg::DIGIT_W-1:0]   digit_b;
   logic [slcd_pkg::DIGIT_W-1:0]   digit_c;
   logic [slcd_pkg::DIGIT_W-1:0]   digit_d;
   logic [slcd_pkg::BYTE_W-1:0]    command_byte;
   logic                           point_on;
   logic                           backlight_on;

   modport source (output valid, cmd, digit_a, digit_b, digit_c, digit_d, command_byte,
                   point_on, backlight_on, input ready);
   modport sink   (input valid, cmd, digit_a, digit_b, digit_c, digit_d, command_byte,
                   point_on, backlight_on, output ready);
endinterface

// Response channel: pin levels and status after each tick.
interface slcd_rsp_if;
   logic valid;
   logic ready;
   logic select_level;
   logic strobe_level;
   logic data_level;
   logic backlight_level;
   logic busy_res;
   logic rejected;

   modport source (output valid, select_level, strobe_level, data_level, backlight_level,
                   busy_res, rejected, input ready);
   modport sink   (input valid, select_level, strobe_level, data_level, backlight_level,
                   busy_res, rejected, output ready);
endinterface

// CSR write channel.
interface slcd_csr_if;
   logic                             valid;
   logic                             ready;
   logic [slcd_pkg::CSR_IDX_W-1:0]   index;
   logic [slcd_pkg::TICK_W-1:0]      data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

// ===== sv/segment_lcd_serial_writer.sv =====
// Top level of the segment LCD serial writer: pin sequencer and response register.
// Depends on slcd_pkg and the channel interfaces in slcd_if.sv.
//
//   channel   direction  interface     carries
//   req_chan  in         slcd_req_if   request code, digits, command byte, levels
//   rsp_chan  out        slcd_rsp_if   chip select, strobe, data, backlight, status
//   csr_chan  in         slcd_csr_if   strobe low and high tick counts
//
// One request transaction is taken per cycle; its response is ready in the next
// cycle from the response register, so the sustained rate is one per cycle.
// The request side stalls only while a response waits and the response side is stalled.
// CSR writes are taken in every cycle.
// Reset is synchronous and restores the reset digits, timing and an idle sequencer; pin levels are not reset.
`timescale 1ns / 1ps

module segment_lcd_serial_writer (
   input  logic       clock,
   input  logic       reset,
   slcd_req_if.sink   req_chan,
   slcd_rsp_if.source rsp_chan,
   slcd_csr_if.sink   csr_chan
);

   // Timing registers.
   logic [slcd_pkg::TICK_W-1:0] wr_low_ff, wr_low_in;
   logic [slcd_pkg::TICK_W-1:0] wr_high_ff, wr_high_in;

   // Frame state.
   logic [3:0][slcd_pkg::BYTE_W-1:0] segments_ff, segments_in;
   logic                             point_ff, point_in;
   slcd_pkg::frame_kind_type         kind_ff, kind_in;
   slcd_pkg::bit_pos_type            pos_ff, pos_in;
   logic [slcd_pkg::TICK_W-1:0]      phase_cnt_ff, phase_cnt_in;
   logic                             strobe_low_ff, strobe_low_in;
   logic [slcd_pkg::BYTE_W-1:0]      held_cmd_ff, held_cmd_in;
   logic                             backlight_ff, backlight_in;

   // Response register.
   logic rsp_valid_ff, rsp_valid_in;
   logic select_ff, select_in;
   logic strobe_ff, strobe_in;
   logic data_ff, data_in;
   logic rsp_backlight_ff, rsp_backlight_in;
   logic busy_ff, busy_in;
   logic rejected_ff, rejected_in;

   logic req_fire;
   logic busy_now;
   logic is_request;
   logic [slcd_pkg::TICK_W-1:0] phase_inc;
   slcd_pkg::bit_pos_type       pos_inc;
   slcd_pkg::bit_pos_type       byte_off;
   logic [2:0]                  byte_idx;
   logic [slcd_pkg::BYTE_W-1:0] cur_byte;
   logic [slcd_pkg::BYTE_W-1:0] seg_c;
   logic                        data_bit;

   // Handshakes: the request side moves whenever the response register can be refilled.
   assign req_chan.ready = !rsp_valid_ff || rsp_chan.ready;
   assign csr_chan.ready = 1'b1;
   assign req_fire       = req_chan.valid && req_chan.ready;

   // Configuration writes; indexes past the list are ignored.
   always_comb begin
      wr_low_in  = wr_low_ff;
      wr_high_in = wr_high_ff;
      if (csr_chan.valid) begin
         case (csr_chan.index)
            slcd_pkg::CSR_WR_LOW:  wr_low_in  = csr_chan.data;
            slcd_pkg::CSR_WR_HIGH: wr_high_in = csr_chan.data;
            default: ;
         endcase
      end
   end

   // Next frame state for one tick.
   assign busy_now   = (kind_ff != slcd_pkg::KIND_IDLE);
   assign is_request = (req_chan.cmd >= slcd_pkg::CMD_DIGITS) &&
                       (req_chan.cmd <= slcd_pkg::CMD_BACKLIGHT);
   assign phase_inc  = phase_cnt_ff + 1'b1;
   assign pos_inc    = pos_ff + 1'b1;

   // Segment byte of the third digit; its top bit is replaced by the point.
   assign seg_c      = slcd_pkg::seg_code(req_chan.digit_c);

   always_comb begin
      segments_in   = segments_ff;
      point_in      = point_ff;
      kind_in       = kind_ff;
      pos_in        = pos_ff;
      phase_cnt_in  = phase_cnt_ff;
      strobe_low_in = strobe_low_ff;
      held_cmd_in   = held_cmd_ff;
      backlight_in  = backlight_ff;
      rejected_in   = 1'b0;
      if (busy_now) begin
         rejected_in  = is_request;
         phase_cnt_in = phase_inc;
         if (strobe_low_ff) begin
            // End of the low phase moves to the high phase of the same bit.
            if (phase_inc >= wr_low_ff) begin
               strobe_low_in = 1'b0;
               phase_cnt_in  = '0;
            end
         end else if (phase_inc >= wr_high_ff) begin
            // End of the high phase moves to the next bit or ends the frame.
            phase_cnt_in = '0;
            if (pos_inc >= slcd_pkg::frame_len(kind_ff)) begin
               kind_in       = slcd_pkg::KIND_IDLE;
               pos_in        = '0;
               strobe_low_in = 1'b0;
            end else begin
               pos_in        = pos_inc;
               strobe_low_in = 1'b1;
            end
         end
      end else begin
         case (req_chan.cmd)
            slcd_pkg::CMD_DIGITS: begin
               segments_in[0] = slcd_pkg::seg_code(req_chan.digit_a);
               segments_in[1] = slcd_pkg::seg_code(req_chan.digit_b);
               segments_in[2] = {point_ff, seg_c[6:0]};
               segments_in[3] = slcd_pkg::seg_code(req_chan.digit_d);
               kind_in        = slcd_pkg::KIND_DIGITS;
            end
            slcd_pkg::CMD_POINT: begin
               point_in          = req_chan.point_on;
               segments_in[2][7] = req_chan.point_on;
               kind_in           = slcd_pkg::KIND_DIGITS;
            end
            slcd_pkg::CMD_SEND: begin
               held_cmd_in = req_chan.command_byte;
               kind_in     = slcd_pkg::KIND_CMD;
            end
            slcd_pkg::CMD_CLEAR: begin
               kind_in = slcd_pkg::KIND_CLEAR;
            end
            slcd_pkg::CMD_BACKLIGHT: begin
               backlight_in = req_chan.backlight_on;
            end
            default: ;
         endcase
         // Every frame starts on its first bit with the strobe low.
         if (kind_in != slcd_pkg::KIND_IDLE) begin
            pos_in        = '0;
            phase_cnt_in  = '0;
            strobe_low_in = 1'b1;
         end
      end
   end

   // Byte of the digit frame that holds the current bit.
   assign byte_off = pos_in - slcd_pkg::POS_W'(9);
   assign byte_idx = byte_off[5:3];

   always_comb begin
      case (byte_idx)
         3'd0, 3'd1, 3'd2: cur_byte = 8'hff;
         3'd3:             cur_byte = segments_in[0];
         3'd4:             cur_byte = segments_in[1];
         3'd5:             cur_byte = segments_in[2];
         3'd6:             cur_byte = segments_in[3];
         default:          cur_byte = 8'h00;
      endcase
   end

   // Serial data bit at the new position: header, then address or payload.
   always_comb begin
      data_bit = 1'b0;
      if (kind_in != slcd_pkg::KIND_IDLE) begin
         if (pos_in == slcd_pkg::POS_W'(0)) begin
            data_bit = 1'b1;
         end else if (pos_in == slcd_pkg::POS_W'(1)) begin
            data_bit = 1'b0;
         end else if (pos_in == slcd_pkg::POS_W'(2)) begin
            data_bit = (kind_in != slcd_pkg::KIND_CMD);
         end else begin
            case (kind_in)
               slcd_pkg::KIND_CMD: begin
                  if (pos_in <= slcd_pkg::POS_W'(10)) begin
                     data_bit = held_cmd_in[3'(slcd_pkg::POS_W'(10) - pos_in)];
                  end
               end
               slcd_pkg::KIND_DIGITS: begin
                  // Address 000011, then the eight payload bytes.
                  if (pos_in <= slcd_pkg::POS_W'(8)) begin
                     data_bit = (pos_in >= slcd_pkg::POS_W'(7));
                  end else if (pos_in < slcd_pkg::POS_W'(slcd_pkg::DIGIT_BITS)) begin
                     data_bit = cur_byte[~byte_off[2:0]];
                  end
               end
               default: data_bit = 1'b0;
            endcase
         end
      end
   end

   // Response values for the tick being taken.
   always_comb begin
      rsp_valid_in     = rsp_valid_ff;
      select_in        = select_ff;
      strobe_in        = strobe_ff;
      data_in          = data_ff;
      rsp_backlight_in = rsp_backlight_ff;
      busy_in          = busy_ff;
      if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
      if (req_fire) begin
         rsp_valid_in     = 1'b1;
         select_in        = (kind_in == slcd_pkg::KIND_IDLE);
         strobe_in        = !((kind_in != slcd_pkg::KIND_IDLE) && strobe_low_in);
         data_in          = data_bit;
         rsp_backlight_in = backlight_in;
         busy_in          = (kind_in != slcd_pkg::KIND_IDLE);
      end
   end

   // Register update.
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_low_ff     <= slcd_pkg::WR_LOW_RESET;
         wr_high_ff    <= slcd_pkg::WR_HIGH_RESET;
         segments_ff   <= slcd_pkg::SEGMENTS_RESET;
         point_ff      <= 1'b1;
         kind_ff       <= slcd_pkg::KIND_IDLE;
         pos_ff        <= '0;
         phase_cnt_ff  <= '0;
         strobe_low_ff <= 1'b0;
         held_cmd_ff   <= '0;
         backlight_ff  <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         wr_low_ff    <= wr_low_in;
         wr_high_ff   <= wr_high_in;
         rsp_valid_ff <= rsp_valid_in;
         if (req_fire) begin
            segments_ff   <= segments_in;
            point_ff      <= point_in;
            kind_ff       <= kind_in;
            pos_ff        <= pos_in;
            phase_cnt_ff  <= phase_cnt_in;
            strobe_low_ff <= strobe_low_in;
            held_cmd_ff   <= held_cmd_in;
            backlight_ff  <= backlight_in;
         end
      end
   end

   // Response payload needs no reset.
   always_ff @(posedge clock) begin
      select_ff        <= select_in;
      strobe_ff        <= strobe_in;
      data_ff          <= data_in;
      rsp_backlight_ff <= rsp_backlight_in;
      busy_ff          <= busy_in;
      if (req_fire) begin
         rejected_ff <= rejected_in;
      end
   end

   assign rsp_chan.valid           = rsp_valid_ff;
   assign rsp_chan.select_level    = select_ff;
   assign rsp_chan.strobe_level    = strobe_ff;
   assign rsp_chan.data_level      = data_ff;
   assign rsp_chan.backlight_level = rsp_backlight_ff;
   assign rsp_chan.busy_res        = busy_ff;
   assign rsp_chan.rejected        = rejected_ff;

`ifndef ASSERT_OFF
   // An idle sequencer sits at the first bit with the strobe high.
   a_idle_rest: assert property (@(posedge clock) disable iff (reset)
      (kind_ff == slcd_pkg::KIND_IDLE) |-> (pos_ff == '0) && !strobe_low_ff)
      else $error("idle sequencer not at rest");

   // The bit position stays inside the frame being sent.
   a_pos_bound: assert property (@(posedge clock) disable iff (reset)
      (kind_ff != slcd_pkg::KIND_IDLE) |-> (pos_ff < slcd_pkg::frame_len(kind_ff)))
      else $error("bit position past end of frame");

   // A frame request taken while idle starts a frame in its low phase.
   a_frame_start: assert property (@(posedge clock) disable iff (reset)
      (req_fire && (kind_ff == slcd_pkg::KIND_IDLE) &&
       (req_chan.cmd == slcd_pkg::CMD_DIGITS || req_chan.cmd == slcd_pkg::CMD_POINT ||
        req_chan.cmd == slcd_pkg::CMD_SEND || req_chan.cmd == slcd_pkg::CMD_CLEAR))
      |=> (kind_ff != slcd_pkg::KIND_IDLE) && strobe_low_ff && rsp_chan.busy_res)
      else $error("frame did not start");

   // An idle response shows chip select and strobe high and the data pin low.
   a_idle_pins: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && !rsp_chan.busy_res) |->
      rsp_chan.select_level && rsp_chan.strobe_level && !rsp_chan.data_level)
      else $error("pins active while idle");
`endif

endmodule

// ===== dv/tb_segment_lcd_serial_writer.sv =====
// Self-checking testbench for the segment LCD serial writer: per-tick pin levels and status.
// Depends on slcd_pkg, the channel interfaces in slcd_if.sv and segment_lcd_serial_writer.
// An in-bench pin sequencer forecasts every response, which is compared field by field.
`timescale 1ns / 1ps

module tb_segment_lcd_serial_writer;

   // Request codes that the block does not use; they must neither act nor be rejected.
   localparam logic [slcd_pkg::CMD_W-1:0] CMD_UNUSED_LO = 3'd6;
   localparam logic [slcd_pkg::CMD_W-1:0] CMD_UNUSED_HI = 3'd7;

   // Segment bytes per digit code, code zero in the lowest byte.
   localparam logic [15:0][7:0] GLYPHS = {
      8'h00, 8'h00, 8'h00, 8'h00, 8'h78, 8'h5e, 8'h6f, 8'h7f,
      8'h0e, 8'h7b, 8'h6b, 8'h66, 8'h2f, 8'h3d, 8'h06, 8'h5f
   };

   // Quiet cycles tolerated; well above the longest response hold-off.
   localparam int QUIET_LIMIT = 5000;
   localparam int HOLD_CYCLES = 200;
   // Response count at which the long hold-off starts, inside the first random phase.
   localparam int STALL_AT    = 1150;
   // Length of the stretch in which neither side idles.
   localparam int CALM_TICKS  = 100;

   typedef struct packed {
      logic [slcd_pkg::CMD_W-1:0]   cmd;
      logic [slcd_pkg::DIGIT_W-1:0] digit_a;
      logic [slcd_pkg::DIGIT_W-1:0] digit_b;
      logic [slcd_pkg::DIGIT_W-1:0] digit_c;
      logic [slcd_pkg::DIGIT_W-1:0] digit_d;
      logic [slcd_pkg::BYTE_W-1:0]  command_byte;
      logic                         point_on;
      logic                         backlight_on;
   } lcd_tick_type;

   typedef struct packed {
      logic select_level;
      logic strobe_level;
      logic data_level;
      logic backlight_level;
      logic busy_res;
      logic rejected;
   } pin_state_type;

   logic clock;
   logic reset;

   slcd_req_if req_if ();
   slcd_rsp_if rsp_if ();
   slcd_csr_if csr_if ();

   segment_lcd_serial_writer dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_if),
      .rsp_chan (rsp_if),
      .csr_chan (csr_if)
   );

   // Ticks waiting to be driven and pin levels still to arrive.
   lcd_tick_type  ticks_pending [$];
   pin_state_type pins_due [$];

   int ticks_queued;
   int ticks_taken;
   int pins_checked;
   int mismatches;
   int quiet_cycles;
   int stall_left;
   int calm_from;
   bit long_stall_done;
   bit req_taken_last;
   lcd_tick_type next_tick;

   // Forecast state of the pin sequencer.
   logic [slcd_pkg::TICK_W-1:0] low_ticks;
   logic [slcd_pkg::TICK_W-1:0] high_ticks;
   logic [7:0]                  shown [4];
   logic                        point_lit;
   slcd_pkg::frame_kind_type    frame_now;
   logic [15:0]                 bit_idx;
   logic [slcd_pkg::TICK_W-1:0] phase_cnt;
   logic                        in_low;
   logic [7:0]                  cmd_hold;
   logic                        backlight;

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Number of bits in a frame of the given kind.
   function automatic int frame_bits(input slcd_pkg::frame_kind_type kind);
      case (kind)
         slcd_pkg::KIND_CMD:    return slcd_pkg::CMD_BITS;
         slcd_pkg::KIND_CLEAR:  return 9 + 4 * slcd_pkg::CLEAR_NIBBLES;
         slcd_pkg::KIND_DIGITS: return slcd_pkg::DIGIT_BITS;
         default:               return 0;
      endcase
   endfunction

   // Level of the data pin for the bit now on the wire.
   function automatic logic frame_level();
      int   pos;
      int   slot;
      logic [7:0] payload;
      pos = bit_idx;
      if (frame_now == slcd_pkg::KIND_IDLE) return 1'b0;
      if (pos == 0) return 1'b1;
      if (pos == 1) return 1'b0;
      if (pos == 2) return frame_now != slcd_pkg::KIND_CMD;
      if (frame_now == slcd_pkg::KIND_CMD) return (pos <= 10) ? cmd_hold[10 - pos] : 1'b0;
      if (frame_now == slcd_pkg::KIND_CLEAR) return 1'b0;
      // Digit frames write from address 3: the last two address bits are set.
      if (pos <= 8) return pos >= 7;
      slot = (pos - 9) / 8;
      if (slot < 3) payload = 8'hff;
      else if (slot < 7) payload = shown[slot - 3];
      else payload = 8'h00;
      return payload[7 - ((pos - 9) % 8)];
   endfunction

   task automatic open_frame(input slcd_pkg::frame_kind_type kind);
      frame_now = kind;
      bit_idx   = '0;
      phase_cnt = '0;
      in_low    = 1'b1;
   endtask

   task automatic apply_point();
      shown[2][7] = point_lit;
   endtask

   // Advances the sequencer by one tick and forecasts the pins after it.
   task automatic advance_pin_sequencer(input lcd_tick_type t);
      pin_state_type pins;
      logic          rej;
      logic          busy;
      rej = 1'b0;
      if (frame_now != slcd_pkg::KIND_IDLE) begin
         // A request while a frame is out is dropped; codes digits to backlight are also flagged.
         rej = (t.cmd >= slcd_pkg::CMD_DIGITS) && (t.cmd <= slcd_pkg::CMD_BACKLIGHT);
         phase_cnt = phase_cnt + 1'b1;
         if (in_low) begin
            if (phase_cnt >= low_ticks) begin
               in_low    = 1'b0;
               phase_cnt = '0;
            end
         end else if (phase_cnt >= high_ticks) begin
            phase_cnt = '0;
            bit_idx   = bit_idx + 1'b1;
            if (bit_idx >= frame_bits(frame_now)) begin
               frame_now = slcd_pkg::KIND_IDLE;
               bit_idx   = '0;
               in_low    = 1'b0;
            end else begin
               in_low = 1'b1;
            end
         end
      end else begin
         case (t.cmd)
            slcd_pkg::CMD_DIGITS: begin
               shown[0] = GLYPHS[t.digit_a];
               shown[1] = GLYPHS[t.digit_b];
               shown[2] = GLYPHS[t.digit_c];
               shown[3] = GLYPHS[t.digit_d];
               apply_point();
               open_frame(slcd_pkg::KIND_DIGITS);
            end
            slcd_pkg::CMD_POINT: begin
               point_lit = t.point_on;
               apply_point();
               open_frame(slcd_pkg::KIND_DIGITS);
            end
            slcd_pkg::CMD_SEND: begin
               cmd_hold = t.command_byte;
               open_frame(slcd_pkg::KIND_CMD);
            end
            slcd_pkg::CMD_CLEAR: open_frame(slcd_pkg::KIND_CLEAR);
            slcd_pkg::CMD_BACKLIGHT: backlight = t.backlight_on;
            default: ;
         endcase
      end
      busy = frame_now != slcd_pkg::KIND_IDLE;
      pins.select_level    = !busy;
      pins.strobe_level    = !(busy && in_low);
      pins.data_level      = frame_level();
      pins.backlight_level = backlight;
      pins.busy_res        = busy;
      pins.rejected        = rej;
      pins_due.push_back(pins);
   endtask

   task automatic check_level(input string pin, input logic want, input logic got);
      if (got !== want) begin
         mismatches++;
         $display("%0t: %s mismatch, expected %0b, actual %0b", $time, pin, want, got);
      end
   endtask

   // Handshake sampling, forecasting, checking and the quiet-cycle watchdog.
   always @(posedge clock) begin
      pin_state_type want;
      lcd_tick_type  seen;
      if (reset) begin
         req_taken_last = 1'b0;
         quiet_cycles   = 0;
         low_ticks      = slcd_pkg::WR_LOW_RESET;
         high_ticks     = slcd_pkg::WR_HIGH_RESET;
         shown[0]       = 8'h5e;
         shown[1]       = 8'h78;
         shown[2]       = 8'h7f;
         shown[3]       = 8'h0e;
         point_lit      = 1'b1;
         frame_now      = slcd_pkg::KIND_IDLE;
         bit_idx        = '0;
         phase_cnt      = '0;
         in_low         = 1'b0;
         cmd_hold       = '0;
         backlight      = 1'b0;
      end else begin
         req_taken_last = req_if.valid && req_if.ready;
         quiet_cycles++;
         if (csr_if.valid && csr_if.ready) begin
            quiet_cycles = 0;
            case (csr_if.index)
               slcd_pkg::CSR_WR_LOW:  low_ticks = csr_if.data;
               slcd_pkg::CSR_WR_HIGH: high_ticks = csr_if.data;
               default: ;
            endcase
         end
         if (req_taken_last) begin
            quiet_cycles         = 0;
            seen.cmd             = req_if.cmd;
            seen.digit_a         = req_if.digit_a;
            seen.digit_b         = req_if.digit_b;
            seen.digit_c         = req_if.digit_c;
            seen.digit_d         = req_if.digit_d;
            seen.command_byte    = req_if.command_byte;
            seen.point_on        = req_if.point_on;
            seen.backlight_on    = req_if.backlight_on;
            advance_pin_sequencer(seen);
            ticks_taken++;
         end
         if (rsp_if.valid && rsp_if.ready) begin
            quiet_cycles = 0;
            pins_checked++;
            if (pins_due.size() == 0) begin
               mismatches++;
               $display("%0t: unexpected response transaction, expected none, actual %b",
                        $time, {rsp_if.select_level, rsp_if.strobe_level,
                                rsp_if.data_level, rsp_if.backlight_level,
                                rsp_if.busy_res, rsp_if.rejected});
            end else begin
               want = pins_due.pop_front();
               check_level("select_level", want.select_level, rsp_if.select_level);
               check_level("strobe_level", want.strobe_level, rsp_if.strobe_level);
               check_level("data_level", want.data_level, rsp_if.data_level);
               check_level("backlight_level", want.backlight_level, rsp_if.backlight_level);
               check_level("busy_res", want.busy_res, rsp_if.busy_res);
               check_level("rejected", want.rejected, rsp_if.rejected);
            end
         end
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("%0t: no transaction for %0d cycles", $time, QUIET_LIMIT);
            $display("[FAIL] regression broken");
            $finish;
         end
      end
   end

   // Request driver: idles at random except in a calm stretch of the run.
   always @(negedge clock) begin
      if (!reset && (!req_if.valid || req_taken_last)) begin
         if (ticks_pending.size() != 0 &&
             ((ticks_taken >= calm_from && ticks_taken < calm_from + CALM_TICKS) ||
              $urandom_range(99) >= 32)) begin
            next_tick            = ticks_pending.pop_front();
            req_if.valid        <= 1'b1;
            req_if.cmd          <= next_tick.cmd;
            req_if.digit_a      <= next_tick.digit_a;
            req_if.digit_b      <= next_tick.digit_b;
            req_if.digit_c      <= next_tick.digit_c;
            req_if.digit_d      <= next_tick.digit_d;
            req_if.command_byte <= next_tick.command_byte;
            req_if.point_on     <= next_tick.point_on;
            req_if.backlight_on <= next_tick.backlight_on;
         end else begin
            req_if.valid <= 1'b0;
         end
      end
   end

   // Response ready: random stalls, one long hold-off, and a calm stretch.
   always @(negedge clock) begin
      if (reset) begin
         rsp_if.ready <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left   <= stall_left - 1;
         rsp_if.ready <= 1'b0;
      end else if (!long_stall_done && pins_checked >= STALL_AT) begin
         long_stall_done <= 1'b1;
         stall_left      <= HOLD_CYCLES;
         rsp_if.ready    <= 1'b0;
      end else if (pins_checked >= calm_from && pins_checked < calm_from + CALM_TICKS) begin
         rsp_if.ready <= 1'b1;
      end else begin
         rsp_if.ready <= ($urandom_range(99) >= 32);
      end
   end

   task automatic queue_tick(input lcd_tick_type t);
      ticks_pending.push_back(t);
      ticks_queued++;
   endtask

   function automatic lcd_tick_type random_tick();
      lcd_tick_type t;
      int           roll;
      roll           = $urandom_range(99);
      t.digit_a      = slcd_pkg::DIGIT_W'($urandom);
      t.digit_b      = slcd_pkg::DIGIT_W'($urandom);
      t.digit_c      = slcd_pkg::DIGIT_W'($urandom);
      t.digit_d      = slcd_pkg::DIGIT_W'($urandom);
      t.command_byte = slcd_pkg::BYTE_W'($urandom);
      t.point_on     = 1'($urandom);
      t.backlight_on = 1'($urandom);
      if (roll < 80) begin
         t.cmd = slcd_pkg::CMD_NONE;
      end else if (roll < 97) begin
         t.cmd = slcd_pkg::CMD_W'($urandom_range(slcd_pkg::CMD_DIGITS,
                                                 slcd_pkg::CMD_BACKLIGHT));
      end else begin
         t.cmd = slcd_pkg::CMD_W'($urandom_range(CMD_UNUSED_LO, CMD_UNUSED_HI));
      end
      return t;
   endfunction

   task automatic request(input logic [slcd_pkg::CMD_W-1:0] cmd, input logic [15:0] digits,
                          input logic [7:0] cmd_byte, input logic pt, input logic bl);
      lcd_tick_type t;
      t.cmd          = cmd;
      {t.digit_a, t.digit_b, t.digit_c, t.digit_d} = digits;
      t.command_byte = cmd_byte;
      t.point_on     = pt;
      t.backlight_on = bl;
      queue_tick(t);
   endtask

   // Waits until every queued tick is taken and every forecast response has come.
   task automatic drain_all();
      while (ticks_taken != ticks_queued || pins_due.size() != 0)
         @(negedge clock);
   endtask

   // Feeds quiet ticks until the frame in flight has ended.
   task automatic run_out_frame();
      lcd_tick_type t;
      drain_all();
      while (frame_now != slcd_pkg::KIND_IDLE) begin
         repeat (32) begin
            t     = random_tick();
            t.cmd = slcd_pkg::CMD_NONE;
            queue_tick(t);
         end
         drain_all();
      end
   endtask

   task automatic write_csr(input logic [slcd_pkg::CSR_IDX_W-1:0] idx,
                            input logic [slcd_pkg::TICK_W-1:0] val);
      @(negedge clock);
      csr_if.index <= idx;
      csr_if.data  <= val;
      csr_if.valid <= 1'b1;
      do @(posedge clock); while (!(csr_if.valid && csr_if.ready));
      @(negedge clock);
      csr_if.valid <= 1'b0;
   endtask

   task automatic set_timing(input logic [slcd_pkg::TICK_W-1:0] low,
                             input logic [slcd_pkg::TICK_W-1:0] high);
      write_csr(slcd_pkg::CSR_WR_LOW, low);
      write_csr(slcd_pkg::CSR_WR_HIGH, high);
   endtask

   task automatic random_ticks(input int count);
      repeat (count) queue_tick(random_tick());
      run_out_frame();
   endtask

   // Stimulus: reset, directed frames, random phases over two timings, then zero and longest timings.
   initial begin
      req_if.valid        = 1'b0;
      req_if.cmd          = slcd_pkg::CMD_NONE;
      req_if.digit_a      = '0;
      req_if.digit_b      = '0;
      req_if.digit_c      = '0;
      req_if.digit_d      = '0;
      req_if.command_byte = '0;
      req_if.point_on     = 1'b0;
      req_if.backlight_on = 1'b0;
      rsp_if.ready        = 1'b0;
      csr_if.valid        = 1'b0;
      csr_if.index        = slcd_pkg::CSR_WR_LOW;
      csr_if.data         = '0;
      ticks_queued        = 0;
      ticks_taken         = 0;
      pins_checked        = 0;
      mismatches          = 0;
      stall_left          = 0;
      calm_from           = 1000000;
      long_stall_done     = 1'b0;
      reset               = 1'b1;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Reset timing: idle tick, backlight on, and a command frame.
      request(slcd_pkg::CMD_NONE, 16'h0000, 8'h00, 1'b0, 1'b0);
      request(slcd_pkg::CMD_BACKLIGHT, 16'h0000, 8'h00, 1'b0, 1'b1);
      request(slcd_pkg::CMD_SEND, 16'h0000, 8'ha5, 1'b0, 1'b0);
      run_out_frame();

      // Fastest strobe: blank codes with the reset point, every later request arriving while busy.
      set_timing(10'd1, 10'd1);
      request(slcd_pkg::CMD_DIGITS, 16'hcdef, 8'h00, 1'b0, 1'b0);
      request(slcd_pkg::CMD_SEND, 16'h0000, 8'hff, 1'b0, 1'b0);
      request(slcd_pkg::CMD_BACKLIGHT, 16'h0000, 8'h00, 1'b0, 1'b0);
      request(slcd_pkg::CMD_CLEAR, 16'h0000, 8'h00, 1'b0, 1'b0);
      request(slcd_pkg::CMD_POINT, 16'h0000, 8'h00, 1'b0, 1'b0);
      request(slcd_pkg::CMD_DIGITS, 16'hffff, 8'h00, 1'b1, 1'b1);
      request(CMD_UNUSED_HI, 16'h0000, 8'h00, 1'b0, 1'b0);
      run_out_frame();

      // Point cleared on the shown digits, then every remaining digit code.
      request(slcd_pkg::CMD_POINT, 16'h0000, 8'h00, 1'b0, 1'b0);
      run_out_frame();
      request(slcd_pkg::CMD_DIGITS, 16'h0123, 8'h00, 1'b0, 1'b0);
      run_out_frame();
      request(slcd_pkg::CMD_DIGITS, 16'h4567, 8'h00, 1'b0, 1'b0);
      run_out_frame();
      request(slcd_pkg::CMD_DIGITS, 16'h89ab, 8'h00, 1'b0, 1'b0);
      run_out_frame();

      // Unused codes at idle do nothing; backlight back off.
      request(CMD_UNUSED_LO, 16'hffff, 8'hff, 1'b1, 1'b1);
      request(CMD_UNUSED_HI, 16'hffff, 8'hff, 1'b1, 1'b1);
      request(slcd_pkg::CMD_BACKLIGHT, 16'h0000, 8'h00, 1'b0, 1'b0);
      drain_all();

      // Random phases over two strobe timings; the second opens with the calm stretch.
      random_ticks(150);
      set_timing(10'd2, 10'd3);
      calm_from = ticks_queued;
      random_ticks(120);

      // Zero in both registers behaves as one tick.
      set_timing(10'd0, 10'd0);
      request(slcd_pkg::CMD_CLEAR, 16'h0000, 8'h00, 1'b0, 1'b0);
      run_out_frame();

      // Longest strobe phases: the opening ticks of a command frame.
      set_timing(10'd1023, 10'd1023);
      request(slcd_pkg::CMD_SEND, 16'h0000, slcd_pkg::BYTE_W'($urandom), 1'b0, 1'b0);
      repeat (40) queue_tick(random_tick());

      drain_all();
      repeat (8) @(posedge clock);
      if (mismatches == 0 && pins_due.size() == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
